// ----- rtl/sgmd_pkg.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// sgmd_pkg: shared constants and types of the Sobel gradient block
// Word widths, CORDIC angle table and the stage record of the arithmetic chain.
// -----------------------------------------------------------------------------
package sgmd_pkg;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int PIXEL_BITS_DEF = 16;
  localparam int HEIGHT_LIMIT   = 4096;
  localparam int STEPS          = 23;
  localparam int GW             = 20;   // gx, gy signed width
  localparam int VW             = 43;   // cordic x/y width (scaled by 2^16, plus growth)
  localparam int ZW             = 28;
  localparam int SQW            = 41;
  localparam int MW             = 19;
  localparam int DW             = 17;
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  typedef struct packed {
    logic                  vld;
    logic signed [VW-1:0]  x;
    logic signed [VW-1:0]  y;
    logic signed [ZW-1:0]  z;
    logic                  zero;
    logic [SQW-1:0]        rem;
    logic [SQW-1:0]        root;
    logic [SQW-1:0]        sbit;
    logic [10:0]           col;
    logic [11:0]           row;
    logic                  last;
  } cell_t;

  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] t;
    case (i)
      0: t = 28'sd2949120;  1: t = 28'sd1740967;  2: t = 28'sd919879;
      3: t = 28'sd466945;   4: t = 28'sd234379;   5: t = 28'sd117304;
      6: t = 28'sd58666;    7: t = 28'sd29335;    8: t = 28'sd14668;
      9: t = 28'sd7334;     10: t = 28'sd3667;    11: t = 28'sd1833;
      12: t = 28'sd917;     13: t = 28'sd458;     14: t = 28'sd229;
      15: t = 28'sd115;     16: t = 28'sd57;      17: t = 28'sd29;
      18: t = 28'sd14;      19: t = 28'sd7;       20: t = 28'sd4;
      21: t = 28'sd2;       22: t = 28'sd1;
      default: t = '0;
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/sgmd_ram.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// sgmd_ram: generic simple dual-port RAM
// One write port and one read port, registered read data. A read of the
// address written in the same cycle returns the old contents.
// -----------------------------------------------------------------------------
module sgmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  // write, and read old contents
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/sgmd_cell.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// sgmd_cell: one step of the arithmetic chain
// One CORDIC rotation and two bits of the integer square root.
// -----------------------------------------------------------------------------
module sgmd_cell #(
  parameter int IDX = 0
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           adv,
  input  wire sgmd_pkg::cell_t din,
  output sgmd_pkg::cell_t      dout
);
  import sgmd_pkg::*;
  cell_t nxt;
  logic [SQW-1:0] trial, r1, b1, t2;
  logic [SQW-1:0] rem1;

  always_comb begin
    nxt = din;
    // rotate toward y = 0
    if (din.y >= 0) begin
      nxt.x = din.x + (din.y >>> IDX);
      nxt.y = din.y - (din.x >>> IDX);
      nxt.z = din.z + atan_entry(IDX);
    end else begin
      nxt.x = din.x - (din.y >>> IDX);
      nxt.y = din.y + (din.x >>> IDX);
      nxt.z = din.z - atan_entry(IDX);
    end
    // first root bit; hold the root once all bits are done
    trial = din.root + din.sbit;
    if (din.sbit == '0) begin
      rem1 = din.rem;
      r1   = din.root;
    end else if (din.rem >= trial) begin
      rem1 = din.rem - trial;
      r1   = (din.root >> 1) + din.sbit;
    end else begin
      rem1 = din.rem;
      r1   = din.root >> 1;
    end
    b1 = din.sbit >> 2;
    // second root bit
    t2 = r1 + b1;
    if (b1 != '0 && rem1 >= t2) begin
      nxt.rem  = rem1 - t2;
      nxt.root = (r1 >> 1) + b1;
    end else begin
      nxt.rem  = rem1;
      nxt.root = (b1 != '0) ? (r1 >> 1) : r1;
    end
    nxt.sbit = b1 >> 2;
  end

  // advance the chain
  always_ff @(posedge clk) begin
    if (rst) dout.vld <= 1'b0;
    else if (adv) dout.vld <= din.vld;
    if (adv) begin
      dout.x <= nxt.x; dout.y <= nxt.y; dout.z <= nxt.z; dout.zero <= nxt.zero;
      dout.rem <= nxt.rem; dout.root <= nxt.root; dout.sbit <= nxt.sbit;
      dout.col <= nxt.col; dout.row <= nxt.row; dout.last <= nxt.last;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/sobel_gradient_mag_dir_top.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// sobel_gradient_mag_dir_top: Sobel gradient magnitude and direction
// Line buffers and a 3x3 window feed a chain of 23 CORDIC/square-root cells.
// -----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  in       | in_valid, in_stall, pixel                 | input word
//  out      | out_valid, out_stall, magnitude, direction, out_col, out_row,
//           | last_in_frame                             | result word
//  cfg      | cfg_we, cfg_index, cfg_data               | register write
// One pixel per clock while the output does not stall; a result word passes through
// line buffer read, window and gradient, squares, 23 chain cells and output.
// Line buffer write-back happens after the read, when the word leaves stage 1.
// The whole chain advances together, so a stalled output stalls input.
// Reset clears counters, window and valid bits, not the line buffers.
module sobel_gradient_mag_dir_top #(
  parameter int MAX_WIDTH  = sgmd_pkg::MAX_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] pixel,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [18:0]      magnitude,
  output logic signed [16:0] direction,
  output logic [10:0]      out_col,
  output logic [11:0]      out_row,
  output logic             last_in_frame,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);
  import sgmd_pkg::*;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int PB = PIXEL_BITS_DEF;

  logic [11:0] image_width;
  logic [12:0] image_height;
  logic [12:0] col_count, row_count;
  logic        adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 12'd640;
      image_height <= 13'd480;
    end else if (cfg_we) begin
      if (cfg_index == REG_WIDTH[0:0]) image_width <= cfg_data[11:0];
      else image_height <= cfg_data;
    end
  end

  // effective sizes and current position
  logic [13:0] w, h;
  logic [12:0] c, r;
  always_comb begin
    w = (image_width == 0) ? 14'd1 :
        ({2'b0, image_width} > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : {2'b0, image_width};
    h = (image_height == 0) ? 14'd1 :
        ({1'b0, image_height} > 14'(HEIGHT_LIMIT)) ? 14'(HEIGHT_LIMIT)
                                                     : {1'b0, image_height};
    c = ({1'b0, col_count} >= w) ? 13'(w - 14'd1) : col_count;
    r = ({1'b0, row_count} >= h) ? 13'd0 : row_count;
  end

  logic acc;
  assign acc = in_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0; row_count <= '0;
    end else if (acc) begin
      if ({1'b0, c} + 14'd1 >= w) begin
        col_count <= '0;
        row_count <= ({1'b0, r} + 14'd1 >= h) ? 13'd0 : r + 13'd1;
      end else col_count <= c + 13'd1;
    end
  end

  // stage 1: read line buffers, write back when the word leaves the stage
  logic [PB-1:0] px;
  logic [PB-1:0] top_rd, mid_rd, top, mid, px1;
  logic [PB-1:0] fwd_top, fwd_mid;
  logic          fwd, wb;
  logic          v1, emit1, last1;
  logic [12:0]   c1, r1;
  assign px  = pixel[PB-1:0];
  assign wb  = v1 && adv;
  // take the word written in the read cycle when both hit one column
  assign top = fwd ? fwd_top : top_rd;
  assign mid = fwd ? fwd_mid : mid_rd;
  sgmd_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_lb0 (
    .clk, .we(wb), .waddr(c1[AW-1:0]), .wdata(mid), .re(acc), .raddr(c[AW-1:0]),
    .rdata(top_rd));
  sgmd_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_lb1 (
    .clk, .we(wb), .waddr(c1[AW-1:0]), .wdata(px1), .re(acc), .raddr(c[AW-1:0]),
    .rdata(mid_rd));
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= acc;
    if (acc) begin
      px1 <= px; c1 <= c; r1 <= r;
      emit1 <= (c >= 13'd2) && (r >= 13'd2);
      last1 <= ({1'b0, c} == w - 14'd1) && ({1'b0, r} == h - 14'd1);
      fwd     <= wb && (c1 == c);
      fwd_top <= mid;
      fwd_mid <= px1;
    end
  end

  // stage 2: window and gradient
  logic [PB-1:0] win [6];
  logic signed [GW-1:0] gx, gy;
  always_comb begin
    gx = GW'(-$signed(GW'(win[0])) + $signed(GW'(top)) - 2*$signed(GW'(win[1]))
         + 2*$signed(GW'(mid)) - $signed(GW'(win[2])) + $signed(GW'(px1)));
    gy = GW'($signed(GW'(win[0])) + 2*$signed(GW'(win[3])) + $signed(GW'(top))
         - $signed(GW'(win[2])) - 2*$signed(GW'(win[5])) - $signed(GW'(px1)));
  end
  logic                  v2, last2;
  logic signed [GW-1:0]  gx2, gy2;
  logic [10:0]           col2;
  logic [11:0]           row2;
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) win[i] <= '0;
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1 && emit1;
      if (v1) begin
        win[0] <= win[3]; win[1] <= win[4]; win[2] <= win[5];
        win[3] <= top; win[4] <= mid; win[5] <= px1;
      end
    end
    if (adv && v1) begin
      gx2 <= gx; gy2 <= gy; last2 <= last1;
      col2 <= 11'(c1 - 13'd1); row2 <= 12'(r1 - 13'd1);
    end
  end

  // stage 3: squares and pre-rotation
  cell_t chain [STEPS+1];
  logic signed [2*GW-1:0] sqx, sqy;
  logic signed [VW-1:0] xs, ys;
  assign sqx = gx2 * gx2;
  assign sqy = gy2 * gy2;
  assign xs  = VW'(gx2) <<< 16;
  assign ys  = VW'(gy2) <<< 16;
  always_ff @(posedge clk) begin
    if (rst) chain[0].vld <= 1'b0;
    else if (adv) chain[0].vld <= v2;
    if (adv) begin
      chain[0].zero <= (gx2 == 0) && (gy2 == 0);
      chain[0].rem  <= SQW'(sqx) + SQW'(sqy);
      chain[0].root <= '0;
      chain[0].sbit <= SQW'(1) << (SQW - 1);
      chain[0].col <= col2; chain[0].row <= row2; chain[0].last <= last2;
      if (gx2 < 0) begin
        if (gy2 >= 0) begin
          chain[0].x <= ys; chain[0].y <= -xs; chain[0].z <= 28'sd5898240;
        end else begin
          chain[0].x <= -ys; chain[0].y <= xs; chain[0].z <= -28'sd5898240;
        end
      end else begin
        chain[0].x <= xs; chain[0].y <= ys; chain[0].z <= '0;
      end
    end
  end

  // cell row
  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    sgmd_cell #(.IDX(i)) u_cell (.clk, .rst, .adv, .din(chain[i]), .dout(chain[i+1]));
  end

  // finish: rounding and saturation of angle
  logic signed [ZW-1:0] zr, d;
  always_comb begin
    zr = (chain[STEPS].z + 28'sd128) >>> 8;
    if (zr > 28'sd46080) d = 28'sd46080;
    else if (zr < -28'sd46080) d = -28'sd46080;
    else d = zr;
  end
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= chain[STEPS].vld;
    if (adv) begin
      magnitude     <= chain[STEPS].root[MW-1:0];
      direction     <= chain[STEPS].zero ? '0 : d[DW-1:0];
      out_col       <= chain[STEPS].col;
      out_row       <= chain[STEPS].row;
      last_in_frame <= chain[STEPS].last;
    end
  end

  // checks
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(magnitude))
    else $error("result changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall) else $error("spurious input stall");
  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (direction <= 17'sd46080) && (direction >= -17'sd46080))
    else $error("direction out of range");
endmodule
`default_nettype wire
